>>> design/cau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Widths, opcodes, status codes, the CORDIC angle table, the per-stage
// pipeline payload and the shared saturation helper.
// ----------------------------------------------------------------------------
package cau_pkg;

   localparam int FRAC_BITS       = 16;
   localparam int DATA_W          = 32;
   localparam int EXT_W           = DATA_W + 1;
   localparam int OP_W            = 4;
   localparam int STATUS_W        = 2;
   localparam int PROD_W          = 2 * DATA_W;
   localparam int SUM_W           = PROD_W + 2;
   localparam int MAG_W           = PROD_W;
   localparam int QUO_W           = DATA_W;
   localparam int SQ_REM_W        = DATA_W + 4;
   localparam int CX_W            = 64;
   localparam int CZ_W            = 34;
   localparam int CORDIC_ITERS    = 30;
   localparam int CORDIC_PRESHIFT = 28;
   localparam int ANGLE_FRAC      = 30;
   localparam int ITER_STAGES     = 32;
   localparam int IDX_W           = 5;

   localparam logic [OP_W-1:0] OP_ADD  = 4'd0;
   localparam logic [OP_W-1:0] OP_SUB  = 4'd1;
   localparam logic [OP_W-1:0] OP_MUL  = 4'd2;
   localparam logic [OP_W-1:0] OP_SMUL = 4'd3;
   localparam logic [OP_W-1:0] OP_DIV  = 4'd4;
   localparam logic [OP_W-1:0] OP_SDIV = 4'd5;
   localparam logic [OP_W-1:0] OP_NEG  = 4'd6;
   localparam logic [OP_W-1:0] OP_CONJ = 4'd7;
   localparam logic [OP_W-1:0] OP_ARG  = 4'd8;
   localparam logic [OP_W-1:0] OP_MAG  = 4'd9;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DIV_ZERO = 2'd1;
   localparam logic [STATUS_W-1:0] ST_SAT      = 2'd2;

   localparam logic [MAG_W-1:0] POS_LIMIT = 64'h0000_0000_7FFF_FFFF;
   localparam logic [MAG_W-1:0] NEG_LIMIT = 64'h0000_0000_8000_0000;

   localparam logic signed [CZ_W-1:0] PI_Q30 = 34'sd3373259426;

   // atan(2^-i) in Q2.30.
   localparam logic [31:0] ATAN_TAB [CORDIC_ITERS] = '{
      32'd843314857, 32'd497837830, 32'd263043837, 32'd133525159, 32'd67021687,
      32'd33543515, 32'd16775851, 32'd8388438, 32'd4194283, 32'd2097149,
      32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536,
      32'd32768, 32'd16384, 32'd8192, 32'd4096, 32'd2048,
      32'd1024, 32'd512, 32'd256, 32'd128, 32'd64,
      32'd32, 32'd16, 32'd8, 32'd4, 32'd2
   };

   typedef struct packed {
      logic                     valid;
      logic [OP_W-1:0]          op;
      logic [DATA_W-1:0]        fix_re;
      logic [DATA_W-1:0]        fix_im;
      logic                     fix_sat;
      logic                     dz;
      logic                     neg_re;
      logic                     neg_im;
      logic                     ovf_re;
      logic                     ovf_im;
      logic [MAG_W-1:0]         rem_re;
      logic [MAG_W-1:0]         rem_im;
      logic [QUO_W-1:0]         low_re;
      logic [QUO_W-1:0]         low_im;
      logic [QUO_W-1:0]         quo_re;
      logic [QUO_W-1:0]         quo_im;
      logic [MAG_W-1:0]         den;
      logic [MAG_W-1:0]         sq_n;
      logic [SQ_REM_W-1:0]      sq_rem;
      logic [QUO_W-1:0]         sq_root;
      logic signed [CX_W-1:0]   cx;
      logic signed [CX_W-1:0]   cy;
      logic signed [CZ_W-1:0]   cz;
      logic                     azero;
   } iter_type;

   // Clamp a sign and magnitude to a 32-bit field; the top bit flags saturation.
   function automatic logic [DATA_W:0] finish_sat(input logic neg,
                                                  input logic [MAG_W-1:0] mag);
      logic [DATA_W:0] r;
      if (neg) begin
         if (mag > NEG_LIMIT) r = {1'b1, 32'h8000_0000};
         else r = {1'b0, ~mag[DATA_W-1:0] + 32'd1};
      end else begin
         if (mag > POS_LIMIT) r = {1'b1, 32'h7FFF_FFFF};
         else r = {1'b0, mag[DATA_W-1:0]};
      end
      return r;
   endfunction

endpackage

>>> design/cau_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit front end
// Operand register, multipliers, exact sums, and the setup of the divide,
// square root and CORDIC lanes in four register stages.
// ----------------------------------------------------------------------------
module cau_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               load,
   input  logic [cau_pkg::OP_W-1:0]           opcode,
   input  logic signed [cau_pkg::DATA_W-1:0]  a_re,
   input  logic signed [cau_pkg::DATA_W-1:0]  a_im,
   input  logic signed [cau_pkg::DATA_W-1:0]  b_re,
   input  logic signed [cau_pkg::DATA_W-1:0]  b_im,
   input  logic signed [cau_pkg::DATA_W-1:0]  scale,
   output cau_pkg::iter_type                  out_stage
);
   import cau_pkg::*;

   typedef struct packed {
      logic [OP_W-1:0]          op;
      logic signed [DATA_W-1:0] ar;
      logic signed [DATA_W-1:0] ai;
      logic signed [DATA_W-1:0] br;
      logic signed [DATA_W-1:0] bi;
      logic signed [DATA_W-1:0] sc;
   } s1_type;

   typedef struct packed {
      logic [OP_W-1:0]          op;
      logic signed [DATA_W-1:0] ar;
      logic signed [DATA_W-1:0] ai;
      logic signed [DATA_W-1:0] sc;
      logic signed [PROD_W-1:0] p0;
      logic signed [PROD_W-1:0] p1;
      logic signed [PROD_W-1:0] p2;
      logic signed [PROD_W-1:0] p3;
      logic signed [PROD_W-1:0] p4;
      logic signed [PROD_W-1:0] p5;
      logic [DATA_W-1:0]        fix_re;
      logic [DATA_W-1:0]        fix_im;
      logic                     fix_sat;
      logic signed [CX_W-1:0]   cx;
      logic signed [CX_W-1:0]   cy;
      logic signed [CZ_W-1:0]   cz;
      logic                     azero;
   } s2_type;

   typedef struct packed {
      logic [OP_W-1:0]          op;
      logic signed [SUM_W-1:0]  sum_re;
      logic signed [SUM_W-1:0]  sum_im;
      logic [MAG_W-1:0]         den;
      logic                     sc_neg;
      logic [DATA_W-1:0]        fix_re;
      logic [DATA_W-1:0]        fix_im;
      logic                     fix_sat;
      logic signed [CX_W-1:0]   cx;
      logic signed [CX_W-1:0]   cy;
      logic signed [CZ_W-1:0]   cz;
      logic                     azero;
   } s3_type;

   logic     s1_valid_ff, s1_valid_in;
   logic     s2_valid_ff, s2_valid_in;
   logic     s3_valid_ff, s3_valid_in;
   s1_type   s1_ff, s1_in;
   s2_type   s2_ff, s2_in;
   s3_type   s3_ff, s3_in;
   iter_type out_ff, out_in;

   function automatic logic [DATA_W:0] sat_sum(input logic signed [EXT_W-1:0] v);
      logic [EXT_W-1:0] u;
      u = v[EXT_W-1] ? (~v + EXT_W'(1)) : v;
      return finish_sat(v[EXT_W-1], MAG_W'(u));
   endfunction

   // Stage 1: operand register.
   always_comb begin
      s1_valid_in = load;
      s1_in       = s1_ff;
      if (load) begin
         s1_in.op = opcode;
         s1_in.ar = a_re;
         s1_in.ai = a_im;
         s1_in.br = b_re;
         s1_in.bi = b_im;
         s1_in.sc = scale;
      end
   end

   // Stage 2: products, simple operations, CORDIC start point.
   always_comb begin
      logic signed [DATA_W-1:0] m0_b, m1_b;
      logic signed [EXT_W-1:0]  e_re, e_im;
      logic [DATA_W:0]          r_re, r_im;
      logic signed [CX_W-1:0]   x0, y0;
      s2_valid_in = s1_valid_ff;
      case (s1_ff.op)
         OP_SMUL: begin
            m0_b = s1_ff.sc;
            m1_b = s1_ff.sc;
         end
         OP_MAG: begin
            m0_b = s1_ff.ar;
            m1_b = s1_ff.ai;
         end
         default: begin
            m0_b = s1_ff.br;
            m1_b = s1_ff.bi;
         end
      endcase
      s2_in.op = s1_ff.op;
      s2_in.ar = s1_ff.ar;
      s2_in.ai = s1_ff.ai;
      s2_in.sc = s1_ff.sc;
      s2_in.p0 = PROD_W'(s1_ff.ar) * PROD_W'(m0_b);
      s2_in.p1 = PROD_W'(s1_ff.ai) * PROD_W'(m1_b);
      s2_in.p2 = PROD_W'(s1_ff.ar) * PROD_W'(s1_ff.bi);
      s2_in.p3 = PROD_W'(s1_ff.ai) * PROD_W'(s1_ff.br);
      s2_in.p4 = PROD_W'(s1_ff.br) * PROD_W'(s1_ff.br);
      s2_in.p5 = PROD_W'(s1_ff.bi) * PROD_W'(s1_ff.bi);

      case (s1_ff.op)
         OP_ADD: begin
            e_re = EXT_W'(s1_ff.ar) + EXT_W'(s1_ff.br);
            e_im = EXT_W'(s1_ff.ai) + EXT_W'(s1_ff.bi);
         end
         OP_SUB: begin
            e_re = EXT_W'(s1_ff.ar) - EXT_W'(s1_ff.br);
            e_im = EXT_W'(s1_ff.ai) - EXT_W'(s1_ff.bi);
         end
         OP_NEG: begin
            e_re = -EXT_W'(s1_ff.ar);
            e_im = -EXT_W'(s1_ff.ai);
         end
         OP_CONJ: begin
            e_re = EXT_W'(s1_ff.ar);
            e_im = -EXT_W'(s1_ff.ai);
         end
         default: begin
            e_re = '0;
            e_im = '0;
         end
      endcase
      r_re = sat_sum(e_re);
      r_im = sat_sum(e_im);
      s2_in.fix_re  = r_re[DATA_W-1:0];
      s2_in.fix_im  = r_im[DATA_W-1:0];
      s2_in.fix_sat = r_re[DATA_W] | r_im[DATA_W];

      // Rotate a left-half-plane vector by pi so the iterations converge.
      x0 = CX_W'(s1_ff.ar) <<< CORDIC_PRESHIFT;
      y0 = CX_W'(s1_ff.ai) <<< CORDIC_PRESHIFT;
      if (s1_ff.ar < 0) begin
         s2_in.cz = (y0 >= 0) ? PI_Q30 : -PI_Q30;
         s2_in.cx = -x0;
         s2_in.cy = -y0;
      end else begin
         s2_in.cz = '0;
         s2_in.cx = x0;
         s2_in.cy = y0;
      end
      s2_in.azero = (s1_ff.ar == 0) && (s1_ff.ai == 0);
   end

   // Stage 3: exact sums and the divisor.
   always_comb begin
      logic [DATA_W-1:0] sc_mag;
      s3_valid_in = s2_valid_ff;
      sc_mag = s2_ff.sc[DATA_W-1] ? (~s2_ff.sc + DATA_W'(1)) : s2_ff.sc;
      s3_in.op = s2_ff.op;
      case (s2_ff.op)
         OP_MUL: begin
            s3_in.sum_re = SUM_W'(s2_ff.p0) - SUM_W'(s2_ff.p1);
            s3_in.sum_im = SUM_W'(s2_ff.p2) + SUM_W'(s2_ff.p3);
         end
         OP_DIV: begin
            s3_in.sum_re = SUM_W'(s2_ff.p0) + SUM_W'(s2_ff.p1);
            s3_in.sum_im = SUM_W'(s2_ff.p3) - SUM_W'(s2_ff.p2);
         end
         OP_MAG: begin
            s3_in.sum_re = SUM_W'(s2_ff.p0) + SUM_W'(s2_ff.p1);
            s3_in.sum_im = '0;
         end
         OP_SMUL: begin
            s3_in.sum_re = SUM_W'(s2_ff.p0);
            s3_in.sum_im = SUM_W'(s2_ff.p1);
         end
         OP_SDIV: begin
            s3_in.sum_re = SUM_W'(s2_ff.ar);
            s3_in.sum_im = SUM_W'(s2_ff.ai);
         end
         default: begin
            s3_in.sum_re = '0;
            s3_in.sum_im = '0;
         end
      endcase
      if (s2_ff.op == OP_SDIV) s3_in.den = MAG_W'(sc_mag);
      else s3_in.den = MAG_W'($unsigned(s2_ff.p4)) + MAG_W'($unsigned(s2_ff.p5));
      s3_in.sc_neg  = s2_ff.sc[DATA_W-1];
      s3_in.fix_re  = s2_ff.fix_re;
      s3_in.fix_im  = s2_ff.fix_im;
      s3_in.fix_sat = s2_ff.fix_sat;
      s3_in.cx      = s2_ff.cx;
      s3_in.cy      = s2_ff.cy;
      s3_in.cz      = s2_ff.cz;
      s3_in.azero   = s2_ff.azero;
   end

   // Stage 4: sign and magnitude, product rescale, divider and root setup.
   always_comb begin
      logic [MAG_W-1:0] mag_re, mag_im;
      logic             neg_re, neg_im, is_sdiv, is_mul;
      logic [DATA_W:0]  f_re, f_im;
      is_sdiv = (s3_ff.op == OP_SDIV);
      is_mul  = (s3_ff.op == OP_MUL) || (s3_ff.op == OP_SMUL);
      mag_re  = s3_ff.sum_re[SUM_W-1] ? MAG_W'(-s3_ff.sum_re) : MAG_W'(s3_ff.sum_re);
      mag_im  = s3_ff.sum_im[SUM_W-1] ? MAG_W'(-s3_ff.sum_im) : MAG_W'(s3_ff.sum_im);
      neg_re  = s3_ff.sum_re[SUM_W-1] ^ (is_sdiv & s3_ff.sc_neg);
      neg_im  = s3_ff.sum_im[SUM_W-1] ^ (is_sdiv & s3_ff.sc_neg);
      f_re    = finish_sat(neg_re, mag_re >> FRAC_BITS);
      f_im    = finish_sat(neg_im, mag_im >> FRAC_BITS);

      out_in.valid   = s3_valid_ff;
      out_in.op      = s3_ff.op;
      out_in.fix_re  = is_mul ? f_re[DATA_W-1:0] : s3_ff.fix_re;
      out_in.fix_im  = is_mul ? f_im[DATA_W-1:0] : s3_ff.fix_im;
      out_in.fix_sat = is_mul ? (f_re[DATA_W] | f_im[DATA_W]) : s3_ff.fix_sat;
      out_in.dz      = ((s3_ff.op == OP_DIV) || is_sdiv) && (s3_ff.den == '0);
      out_in.neg_re  = neg_re;
      out_in.neg_im  = neg_im;
      // The dividend is mag * 2^FRAC_BITS; its part above the 32 quotient
      // bits seeds the remainder, and a seed not below the divisor overflows.
      out_in.rem_re  = mag_re >> (DATA_W - FRAC_BITS);
      out_in.rem_im  = mag_im >> (DATA_W - FRAC_BITS);
      out_in.ovf_re  = (mag_re >> (DATA_W - FRAC_BITS)) >= s3_ff.den;
      out_in.ovf_im  = (mag_im >> (DATA_W - FRAC_BITS)) >= s3_ff.den;
      out_in.low_re  = QUO_W'(mag_re << FRAC_BITS);
      out_in.low_im  = QUO_W'(mag_im << FRAC_BITS);
      out_in.quo_re  = '0;
      out_in.quo_im  = '0;
      out_in.den     = s3_ff.den;
      out_in.sq_n    = mag_re;
      out_in.sq_rem  = '0;
      out_in.sq_root = '0;
      out_in.cx      = s3_ff.cx;
      out_in.cy      = s3_ff.cy;
      out_in.cz      = s3_ff.cz;
      out_in.azero   = s3_ff.azero;
   end

   always_ff @(posedge clock) begin
      s1_ff  <= s1_in;
      s2_ff  <= s2_in;
      s3_ff  <= s3_in;
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_ff.valid <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         out_ff      <= out_in;
      end
   end

   assign out_stage = out_ff;

endmodule

>>> design/cau_iter_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit iteration stage
// One quotient bit for each divider lane, one root bit, and, in stages below
// CORDIC_ITERS, one CORDIC vectoring step, registered.
// ----------------------------------------------------------------------------
module cau_iter_stage (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [cau_pkg::IDX_W-1:0]    stage_idx,
   input  cau_pkg::iter_type            in_stage,
   output cau_pkg::iter_type            out_stage
);
   import cau_pkg::*;

   iter_type out_ff, out_in;

   // Returns the quotient bit above the new remainder.
   function automatic logic [MAG_W:0] div_step(input logic [MAG_W-1:0] rem,
                                               input logic bit_in,
                                               input logic [MAG_W-1:0] den);
      logic [MAG_W:0] t;
      logic [MAG_W:0] d;
      logic [MAG_W:0] diff;
      t    = {rem, bit_in};
      d    = {1'b0, den};
      diff = t - d;
      if (t >= d) return {1'b1, diff[MAG_W-1:0]};
      else return {1'b0, t[MAG_W-1:0]};
   endfunction

   always_comb begin
      logic [MAG_W:0]          st_re, st_im;
      logic [SQ_REM_W-1:0]     sq_t, sq_trial;
      logic signed [CX_W-1:0]  dx, dy;
      logic signed [CZ_W-1:0]  ang;
      out_in = in_stage;

      st_re = div_step(in_stage.rem_re, in_stage.low_re[QUO_W-1], in_stage.den);
      st_im = div_step(in_stage.rem_im, in_stage.low_im[QUO_W-1], in_stage.den);
      out_in.rem_re = st_re[MAG_W-1:0];
      out_in.rem_im = st_im[MAG_W-1:0];
      out_in.quo_re = {in_stage.quo_re[QUO_W-2:0], st_re[MAG_W]};
      out_in.quo_im = {in_stage.quo_im[QUO_W-2:0], st_im[MAG_W]};
      out_in.low_re = in_stage.low_re << 1;
      out_in.low_im = in_stage.low_im << 1;

      sq_t     = {in_stage.sq_rem[SQ_REM_W-3:0], in_stage.sq_n[MAG_W-1 -: 2]};
      sq_trial = SQ_REM_W'({in_stage.sq_root, 2'b01});
      if (sq_t >= sq_trial) begin
         out_in.sq_rem  = sq_t - sq_trial;
         out_in.sq_root = {in_stage.sq_root[QUO_W-2:0], 1'b1};
      end else begin
         out_in.sq_rem  = sq_t;
         out_in.sq_root = {in_stage.sq_root[QUO_W-2:0], 1'b0};
      end
      out_in.sq_n = in_stage.sq_n << 2;

      dx  = in_stage.cy >>> stage_idx;
      dy  = in_stage.cx >>> stage_idx;
      ang = '0;
      if (stage_idx < IDX_W'(CORDIC_ITERS)) begin
         ang = $signed(CZ_W'(ATAN_TAB[stage_idx]));
         if (in_stage.cy >= 0) begin
            out_in.cx = in_stage.cx + dx;
            out_in.cy = in_stage.cy - dy;
            out_in.cz = in_stage.cz + ang;
         end else begin
            out_in.cx = in_stage.cx - dx;
            out_in.cy = in_stage.cy + dy;
            out_in.cz = in_stage.cz - ang;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else begin
         out_ff <= out_in;
      end
   end

   assign out_stage = out_ff;

endmodule

>>> design/cau_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit back end
// Selects the result for the opcode, clamps quotients and roots, rounds the
// angle, and registers the result and its status.
// ----------------------------------------------------------------------------
module cau_back (
   input  logic                                clock,
   input  logic                                reset,
   input  cau_pkg::iter_type                   in_stage,
   output logic                                rsp_valid,
   output logic signed [cau_pkg::DATA_W-1:0]   rsp_res_re,
   output logic signed [cau_pkg::DATA_W-1:0]   rsp_res_im,
   output logic [cau_pkg::STATUS_W-1:0]        rsp_status
);
   import cau_pkg::*;

   localparam logic signed [CZ_W-1:0] ROUND_HALF = CZ_W'(1) << (ANGLE_FRAC - 1 - FRAC_BITS);

   logic                valid_ff, valid_in;
   logic [DATA_W-1:0]   re_ff, re_in;
   logic [DATA_W-1:0]   im_ff, im_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   always_comb begin
      logic [MAG_W-1:0]       q_re, q_im;
      logic [DATA_W:0]        d_re, d_im, root;
      logic signed [CZ_W-1:0] angle;
      logic                   sat;
      // An overflowing quotient stands in as 2^32 and always clamps.
      q_re  = in_stage.ovf_re ? (MAG_W'(1) << QUO_W) : MAG_W'(in_stage.quo_re);
      q_im  = in_stage.ovf_im ? (MAG_W'(1) << QUO_W) : MAG_W'(in_stage.quo_im);
      d_re  = finish_sat(in_stage.neg_re, q_re);
      d_im  = finish_sat(in_stage.neg_im, q_im);
      root  = finish_sat(1'b0, MAG_W'(in_stage.sq_root));
      angle = (in_stage.cz + ROUND_HALF) >>> (ANGLE_FRAC - FRAC_BITS);

      valid_in = in_stage.valid;
      sat      = 1'b0;
      case (in_stage.op)
         OP_ADD, OP_SUB, OP_MUL, OP_SMUL, OP_NEG, OP_CONJ: begin
            re_in = in_stage.fix_re;
            im_in = in_stage.fix_im;
            sat   = in_stage.fix_sat;
         end
         OP_DIV, OP_SDIV: begin
            if (in_stage.dz) begin
               re_in = '0;
               im_in = '0;
            end else begin
               re_in = d_re[DATA_W-1:0];
               im_in = d_im[DATA_W-1:0];
               sat   = d_re[DATA_W] | d_im[DATA_W];
            end
         end
         OP_ARG: begin
            re_in = in_stage.azero ? '0 : DATA_W'(angle);
            im_in = '0;
         end
         OP_MAG: begin
            re_in = root[DATA_W-1:0];
            im_in = '0;
            sat   = root[DATA_W];
         end
         default: begin
            re_in = '0;
            im_in = '0;
         end
      endcase

      if ((in_stage.op == OP_DIV || in_stage.op == OP_SDIV) && in_stage.dz)
         status_in = ST_DIV_ZERO;
      else if (sat)
         status_in = ST_SAT;
      else
         status_in = ST_OK;
   end

   always_ff @(posedge clock) begin
      re_ff     <= re_in;
      im_ff     <= im_in;
      status_ff <= status_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_res_re = $signed(re_ff);
   assign rsp_res_im = $signed(im_ff);
   assign rsp_status = status_ff;

endmodule

>>> design/complex_arithmetic_unit.sv
`timescale 1ns / 1ps
// Every opcode takes the same path through the front end, iteration stages and back end.
// Throughput: one operation per cycle while busy is low; the 32 iteration stages (one quotient
// bit and one root bit each, and a CORDIC step in the first CORDIC_ITERS) set the depth.
// busy is high only while reset is high; results cannot be stalled.
// Synchronous reset empties the pipeline; no result appears for earlier transfers.
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Pipelined Q16.16 complex ALU: add, subtract, multiply, divide, scalar
// forms, negate, conjugate, argument and magnitude, with saturation flags.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [cau_pkg::OP_W-1:0]            req_opcode,
   input  logic signed [cau_pkg::DATA_W-1:0]   req_a_re,
   input  logic signed [cau_pkg::DATA_W-1:0]   req_a_im,
   input  logic signed [cau_pkg::DATA_W-1:0]   req_b_re,
   input  logic signed [cau_pkg::DATA_W-1:0]   req_b_im,
   input  logic signed [cau_pkg::DATA_W-1:0]   req_scale,
   output logic                                rsp_valid,
   output logic signed [cau_pkg::DATA_W-1:0]   rsp_res_re,
   output logic signed [cau_pkg::DATA_W-1:0]   rsp_res_im,
   output logic [cau_pkg::STATUS_W-1:0]        rsp_status
);
   import cau_pkg::*;

   iter_type chain [ITER_STAGES+1];
   logic     load;

   assign busy = reset;
   assign load = start & ~busy;

   cau_front u_front (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .opcode    (req_opcode),
      .a_re      (req_a_re),
      .a_im      (req_a_im),
      .b_re      (req_b_re),
      .b_im      (req_b_im),
      .scale     (req_scale),
      .out_stage (chain[0])
   );

   for (genvar g = 0; g < ITER_STAGES; g++) begin : g_iter
      cau_iter_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .stage_idx (IDX_W'(g)),
         .in_stage  (chain[g]),
         .out_stage (chain[g+1])
      );
   end

   cau_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_stage   (chain[ITER_STAGES]),
      .rsp_valid  (rsp_valid),
      .rsp_res_re (rsp_res_re),
      .rsp_res_im (rsp_res_im),
      .rsp_status (rsp_status)
   );

endmodule
